FILE: sv/laplacian_variance_sharpness_macros.svh
// assertion macros for the laplacian variance sharpness block
// included by files that check their own logic, needs clk and arst_n in scope
`ifndef LAPLACIAN_VARIANCE_SHARPNESS_MACROS_SVH
`define LAPLACIAN_VARIANCE_SHARPNESS_MACROS_SVH

// condition holds at every edge out of reset
`define LVS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define LVS_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define LVS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/lvs_pkg.sv
// shared constants and types of the laplacian variance sharpness block
// no dependencies, used by the interfaces, the finish unit and the top level
`default_nettype none

package lvs_pkg;

	// configuration port
	localparam int unsigned CFG_W        = 13;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned WIDTH_REG_W  = 12;
	localparam int unsigned HEIGHT_REG_W = 13;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd1280;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd720;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// pixel and gray conversion, gray is q8.8
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned GRAY_W     = 16;
	localparam int unsigned GRAY_SUM_W = 24;

	localparam logic [15:0] COEF_RED   = 16'd19595;
	localparam logic [15:0] COEF_GREEN = 16'd38470;
	localparam logic [15:0] COEF_BLUE  = 16'd7471;

	// laplacian is a 20 bit signed value, its square fits 36 bits
	localparam int unsigned LAP_W   = 20;
	localparam int unsigned SQ_BITS = 36;

	// score
	localparam int unsigned QUAL_W    = 17;
	localparam int unsigned Q_FRAC    = 16;
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned VAR_SCALE = 500;

	localparam logic [QUAL_W-1:0] QUAL_ONE = 17'h10000;

endpackage

`default_nettype wire

FILE: sv/lvs_pixel_if.sv
// pixel channel of the laplacian variance sharpness block
// depends on lvs_pkg for the channel width
`default_nettype none

interface lvs_pixel_if;
	logic                            valid;
	logic                            ready;
	logic [lvs_pkg::CHAN_W-1:0]      blue;
	logic [lvs_pkg::CHAN_W-1:0]      green;
	logic [lvs_pkg::CHAN_W-1:0]      red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

`default_nettype wire

FILE: sv/lvs_score_if.sv
// score channel of the laplacian variance sharpness block
// depends on lvs_pkg for the score width
`default_nettype none

interface lvs_score_if;
	logic                            valid;
	logic                            ready;
	logic [lvs_pkg::QUAL_W-1:0]      quality;
	logic                            saturated;

	modport source (output valid, output quality, output saturated, input ready);
	modport sink   (input valid, input quality, input saturated, output ready);
endinterface

`default_nettype wire

FILE: sv/lvs_line_mem.sv
// line store memory: one write and one registered read per cycle
// no dependencies
`default_nettype none

module lvs_line_mem #(
	parameter int DEPTH = 2048,
	parameter int DW    = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/lvs_finish.sv
// end-of-frame unit: serial shift-add multiplier and restoring divider
// depends on lvs_pkg and lvs_score_if
`default_nettype none

module lvs_finish #(
	parameter int NW    = 24,
	parameter int SUM_W = 43,
	parameter int SQ_W  = 60
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NW-1:0]           n,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [SQ_W-1:0]         sumsq,
	output logic                    busy,
	lvs_score_if.source             score
);

	localparam int MB = SUM_W - 1;
	localparam int PW = SQ_W + NW;
	localparam int KW = $clog2(lvs_pkg::DIV_STEPS);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL_SQ,
		F_MUL_MAG,
		F_MUL_N,
		F_CHECK,
		F_DIV,
		F_DONE
	} fin_state_t;

	fin_state_t                  state_q;
	logic [PW-1:0]               acc_q;
	logic [PW-1:0]               a_q;
	logic [MB-1:0]               b_q;
	logic [PW-1:0]               num_q;
	logic [PW-1:0]               dsh_q;
	logic [MB-1:0]               mag_q;
	logic [NW-1:0]               n_q;
	logic [KW-1:0]               k_q;
	logic [lvs_pkg::QUAL_W-1:0]  quot_q;
	logic                        sat_q;
	logic                        valid_q;

	logic [SUM_W-1:0] neg_sum;
	logic [MB-1:0]    mag_in;
	logic [PW-1:0]    acc_step;
	logic [PW-1:0]    den_scaled;
	logic             num_ge;
	logic [PW-1:0]    num_sub;

	assign neg_sum    = -sum;
	assign mag_in     = sum[SUM_W-1] ? neg_sum[MB-1:0] : sum[MB-1:0];
	assign acc_step   = acc_q + (b_q[0] ? a_q : '0);
	assign den_scaled = acc_q * PW'(lvs_pkg::VAR_SCALE);
	assign num_ge     = (num_q >= dsh_q);
	assign num_sub    = num_q - dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			acc_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			num_q   <= '0;
			dsh_q   <= '0;
			mag_q   <= '0;
			n_q     <= '0;
			k_q     <= '0;
			quot_q  <= '0;
			sat_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						a_q     <= PW'(sumsq);
						b_q     <= MB'(n);
						acc_q   <= '0;
						mag_q   <= mag_in;
						n_q     <= n;
						state_q <= F_MUL_SQ;
					end
				end
				// sumsq * n
				F_MUL_SQ: begin
					if (b_q != '0) begin
						acc_q <= acc_step;
						a_q   <= a_q << 1;
						b_q   <= b_q >> 1;
					end else begin
						num_q   <= acc_q;
						a_q     <= PW'(mag_q);
						b_q     <= mag_q;
						acc_q   <= '0;
						state_q <= F_MUL_MAG;
					end
				end
				// sum squared, taken off the numerator
				F_MUL_MAG: begin
					if (b_q != '0) begin
						acc_q <= acc_step;
						a_q   <= a_q << 1;
						b_q   <= b_q >> 1;
					end else begin
						num_q   <= num_q - acc_q;
						a_q     <= PW'(n_q);
						b_q     <= MB'(n_q);
						acc_q   <= '0;
						state_q <= F_MUL_N;
					end
				end
				// n squared, then scaled denominator aligned to the top quotient bit
				F_MUL_N: begin
					if (b_q != '0) begin
						acc_q <= acc_step;
						a_q   <= a_q << 1;
						b_q   <= b_q >> 1;
					end else begin
						dsh_q   <= den_scaled << lvs_pkg::Q_FRAC;
						state_q <= F_CHECK;
					end
				end
				F_CHECK: begin
					if (num_ge) begin
						quot_q  <= lvs_pkg::QUAL_ONE;
						sat_q   <= 1'b1;
						valid_q <= 1'b1;
						state_q <= F_DONE;
					end else begin
						quot_q  <= '0;
						sat_q   <= 1'b0;
						k_q     <= KW'(lvs_pkg::DIV_STEPS - 1);
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (num_ge) begin
						num_q <= num_sub;
					end
					quot_q <= {quot_q[lvs_pkg::QUAL_W-2:0], num_ge};
					dsh_q  <= dsh_q >> 1;
					if (k_q == '0) begin
						valid_q <= 1'b1;
						state_q <= F_DONE;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				F_DONE: begin
					if (score.ready) begin
						valid_q <= 1'b0;
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != F_IDLE);
	assign score.valid     = valid_q;
	assign score.quality   = quot_q;
	assign score.saturated = sat_q;

endmodule

`default_nettype wire

FILE: sv/laplacian_variance_sharpness.sv
// laplacian variance focus measure over a streamed bgr frame
// depends on lvs_pkg, lvs_pixel_if, lvs_score_if, lvs_line_mem, lvs_finish and the macros header
//
// channel | dir | payload                           | transfer at
// pixel   | in  | blue, green, red, 8 bits each     | pixel.valid & pixel.ready
// score   | out | quality 17 bits, saturated 1 bit  | score.valid & score.ready
// cfg     | in  | cfg_index 1 bit, cfg_data 13 bits | cfg_write
//
// one pixel per cycle inside a frame, set by the single read and write port of the line store
// last pixel: it passes the pipeline registers s1 to s4, then the finish unit runs the serial
//   multiplies sumsq * n, |sum| * |sum| and n * n, one check and the divide (none if saturated)
// pixel input stalls after the last pixel of a frame until it has left the pipeline, and the last
//   pixel of the next frame waits until the previous score has been transferred
// reset clears counters, window, sums and flags, loads the default size; the line store is not cleared
`default_nettype none

`include "laplacian_variance_sharpness_macros.svh"

module laplacian_variance_sharpness #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [lvs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lvs_pkg::CFG_W-1:0]         cfg_data,
	lvs_pixel_if.sink                         pixel,
	lvs_score_if.source                       score
);

	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int RB    = $clog2(MAX_HEIGHT);
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int HB    = $clog2(MAX_HEIGHT + 1);
	localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SUM_W = lvs_pkg::LAP_W - 1 + NW;
	localparam int SQ_W  = lvs_pkg::SQ_BITS + NW;
	localparam int GW    = lvs_pkg::GRAY_W;
	localparam int LW    = 2 * GW;
	localparam int LAPW  = lvs_pkg::LAP_W;

	// configuration registers
	logic [lvs_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [lvs_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [WB-1:0]                    eff_w;
	logic [HB-1:0]                    eff_h;
	logic [NW-1:0]                    n_frame;

	// position and flow control
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;
	logic          col_last;
	logic          row_last;
	logic          at_last;
	logic          inner;
	logic          tail_q;
	logic          px_acc;
	logic          fin_busy;

	// gray conversion
	logic [lvs_pkg::GRAY_SUM_W-1:0] gray_sum;
	logic [GW-1:0]                  gray_in;

	// stage 1: line store data back
	logic          valid_s1;
	logic          last_s1;
	logic          inner_s1;
	logic [GW-1:0] gray_s1;
	logic [CB-1:0] x_s1;
	logic [LW-1:0] mem_rd;
	logic [LW-1:0] line_rd;
	logic [LW-1:0] wr_data;
	logic [GW-1:0] mid;
	logic [GW-1:0] top;
	logic          fwd_valid_q;
	logic [CB-1:0] fwd_addr_q;
	logic [LW-1:0] fwd_data_q;

	// 3x3 cross window around the pixel one row up and one column back
	logic [GW-1:0] win_mid1_q;
	logic [GW-1:0] win_mid2_q;
	logic [GW-1:0] win_top_q;
	logic [GW-1:0] win_cur_q;
	logic [LAPW-1:0] lap_next;

	// stage 2 and 3: square, then accumulate
	logic                          add_s2;
	logic                          last_s2;
	logic signed [LAPW-1:0]        lap_s2;
	logic signed [2*LAPW-1:0]      sq_full;
	logic                          add_s3;
	logic                          last_s3;
	logic signed [LAPW-1:0]        lap_s3;
	logic [lvs_pkg::SQ_BITS-1:0]   sq_s3;
	logic                          last_s4;

	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;

	// zero counts as one, oversize clamps to the store size
	always_comb begin
		if (width_q == '0) begin
			eff_w = WB'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = WB'(MAX_WIDTH);
		end else begin
			eff_w = WB'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HB'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			eff_h = HB'(MAX_HEIGHT);
		end else begin
			eff_h = HB'(height_q);
		end
	end

	assign n_frame  = NW'(eff_w) * NW'(eff_h);
	assign col_last = (col_q == CB'(eff_w - WB'(1)));
	assign row_last = (row_q == RB'(eff_h - HB'(1)));
	assign at_last  = col_last && row_last;
	assign inner    = (col_q >= CB'(2)) && (row_q >= RB'(2));

	// hold input while the frame tail drains, and keep the next last pixel
	// back until the finish unit is free
	assign pixel.ready = !tail_q && !(at_last && fin_busy);
	assign px_acc      = pixel.valid && pixel.ready;

	assign gray_sum = lvs_pkg::COEF_RED   * lvs_pkg::GRAY_SUM_W'(pixel.red)
	                + lvs_pkg::COEF_GREEN * lvs_pkg::GRAY_SUM_W'(pixel.green)
	                + lvs_pkg::COEF_BLUE  * lvs_pkg::GRAY_SUM_W'(pixel.blue);
	assign gray_in  = gray_sum[lvs_pkg::GRAY_SUM_W-1 -: GW];

	// line store word: older row on top, newer row below
	lvs_line_mem #(
		.DEPTH (MAX_WIDTH),
		.DW    (LW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (px_acc),
		.rd_addr (col_q),
		.rd_data (mem_rd),
		.wr_en   (valid_s1),
		.wr_addr (x_s1),
		.wr_data (wr_data)
	);

	// a one-column frame reads the entry written in the same cycle
	assign line_rd = (fwd_valid_q && (fwd_addr_q == x_s1)) ? fwd_data_q : mem_rd;
	assign mid     = line_rd[GW-1:0];
	assign top     = line_rd[LW-1:GW];
	assign wr_data = {mid, gray_s1};

	// left + right + up + down - 4 * centre
	assign lap_next = LAPW'(win_mid2_q) + LAPW'(mid) + LAPW'(win_top_q) + LAPW'(win_cur_q)
	                - (LAPW'(win_mid1_q) << 2);

	assign sq_full = lap_s2 * lap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= lvs_pkg::WIDTH_RESET;
			height_q    <= lvs_pkg::HEIGHT_RESET;
			col_q       <= '0;
			row_q       <= '0;
			tail_q      <= 1'b0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			add_s2      <= 1'b0;
			last_s2     <= 1'b0;
			add_s3      <= 1'b0;
			last_s3     <= 1'b0;
			last_s4     <= 1'b0;
			fwd_valid_q <= 1'b0;
			win_mid1_q  <= '0;
			win_mid2_q  <= '0;
			win_top_q   <= '0;
			win_cur_q   <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
		end else begin
			valid_s1 <= px_acc;
			last_s1  <= px_acc && at_last;
			add_s2   <= valid_s1 && inner_s1;
			last_s2  <= last_s1;
			add_s3   <= add_s2;
			last_s3  <= last_s2;
			last_s4  <= last_s3;

			if (valid_s1) begin
				fwd_valid_q <= 1'b1;
			end

			// register write restarts the frame
			if (cfg_write) begin
				unique case (cfg_index)
					lvs_pkg::REG_IMAGE_WIDTH: begin
						width_q <= cfg_data[lvs_pkg::WIDTH_REG_W-1:0];
					end
					lvs_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data[lvs_pkg::HEIGHT_REG_W-1:0];
					end
					default: begin
						width_q <= width_q;
					end
				endcase
				col_q      <= '0;
				row_q      <= '0;
				win_mid1_q <= '0;
				win_mid2_q <= '0;
				win_top_q  <= '0;
				win_cur_q  <= '0;
			end else begin
				if (px_acc) begin
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				if (valid_s1) begin
					win_mid2_q <= win_mid1_q;
					win_mid1_q <= mid;
					win_top_q  <= top;
					win_cur_q  <= gray_s1;
				end
			end

			priority if (px_acc && at_last) begin
				tail_q <= 1'b1;
			end else if (last_s4) begin
				tail_q <= 1'b0;
			end

			// finish unit takes the sums as it starts
			priority if (cfg_write || last_s4) begin
				sum_q   <= '0;
				sumsq_q <= '0;
			end else if (add_s3) begin
				sum_q   <= sum_q + SUM_W'(lap_s3);
				sumsq_q <= sumsq_q + SQ_W'(sq_s3);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (px_acc) begin
			gray_s1  <= gray_in;
			x_s1     <= col_q;
			inner_s1 <= inner;
		end
		if (valid_s1) begin
			lap_s2     <= lap_next;
			fwd_addr_q <= x_s1;
			fwd_data_q <= wr_data;
		end
		lap_s3 <= lap_s2;
		sq_s3  <= sq_full[lvs_pkg::SQ_BITS-1:0];
	end

	lvs_finish #(
		.NW    (NW),
		.SUM_W (SUM_W),
		.SQ_W  (SQ_W)
	) u_finish (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (last_s4),
		.n      (n_frame),
		.sum    (sum_q),
		.sumsq  (sumsq_q),
		.busy   (fin_busy),
		.score  (score)
	);

	// checks
	`LVS_ASSERT_IMP(a_start_when_idle, last_s4, !fin_busy, "finish unit started while busy")
	`LVS_ASSERT_NEXT(a_busy_after_start, last_s4, fin_busy, "finish unit missed its start")
	`LVS_ASSERT_ALWAYS(a_pos_in_frame, (WB'(col_q) < eff_w) && (HB'(row_q) < eff_h), "position outside frame")
	`LVS_ASSERT_IMP(a_sat_is_one, score.valid && score.saturated, score.quality == lvs_pkg::QUAL_ONE, "saturated score not one")

endmodule

`default_nettype wire
